// ----- rtl/core/ptb_pkg.sv -----
// ----------------------------------------------------------------------------
// ptb_pkg
// Shared types and constants for the palette translucency blend block.
// ----------------------------------------------------------------------------
package ptb_pkg;

   // Field widths of one transaction
   localparam int unsigned FUNC_W  = 3;
   localparam int unsigned PIX_W   = 8;
   localparam int unsigned TIDX_W  = 13;
   localparam int unsigned TDATA_W = 32;
   localparam int unsigned STYLE_W = 2;

   // Configuration port
   localparam int unsigned CSR_AW = 3;
   localparam int unsigned CSR_DW = 32;
   localparam logic        CSR_REG_DRAW_STYLE = 1'b0;

   // Function codes
   localparam logic [FUNC_W-1:0] FUNC_DRAW      = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_XLAT = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_FG   = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_BG   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_MIX  = 3'd4;

   // Draw styles
   localparam logic [STYLE_W-1:0] STYLE_PLAIN       = 2'd0;
   localparam logic [STYLE_W-1:0] STYLE_TRANSLATED  = 2'd1;
   localparam logic [STYLE_W-1:0] STYLE_TRANSLUCENT = 2'd2;
   localparam logic [STYLE_W-1:0] STYLE_XLAT_BLEND  = 2'd3;

   // Blend index formation
   localparam logic [TDATA_W-1:0] BLEND_OR_MASK  = 32'hf07c3e1f;
   localparam int unsigned        BLEND_SHIFT_LO = 5;
   localparam int unsigned        BLEND_SHIFT_HI = 19;

   // One transaction as it moves down the pipeline; src carries the
   // foreground index once translation has been applied
   typedef struct packed {
      logic                vld;
      logic [FUNC_W-1:0]   func;
      logic [PIX_W-1:0]    src;
      logic [PIX_W-1:0]    bg;
      logic [TIDX_W-1:0]   tidx;
      logic [TDATA_W-1:0]  tdata;
   } item_type;

   // Output buffer handshake toward the pipeline
   typedef struct packed {
      logic                push;
      logic [PIX_W-1:0]    pix;
   } buf_push_type;

   typedef struct packed {
      logic                full;
      logic                busy;
   } buf_status_type;

endpackage

// ----- rtl/core/ptb_weight_lookup.sv -----
// ----------------------------------------------------------------------------
// ptb_weight_lookup
// Translation table read, then foreground and background weight table reads.
// Loads write each table in the same stage that draws read it.
// ----------------------------------------------------------------------------
module ptb_weight_lookup (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             adv,
   input  logic [ptb_pkg::STYLE_W-1:0]      style,
   input  ptb_pkg::item_type                in_item,
   output ptb_pkg::item_type                s2_item,
   output logic [ptb_pkg::TDATA_W-1:0]      fg_weight,
   output logic [ptb_pkg::TDATA_W-1:0]      bg_weight
);

   logic [ptb_pkg::PIX_W-1:0]   xlat_mem [256];
   logic [ptb_pkg::TDATA_W-1:0] fg_mem   [256];
   logic [ptb_pkg::TDATA_W-1:0] bg_mem   [256];

   ptb_pkg::item_type            s1_ff, s1_in;
   ptb_pkg::item_type            s2_ff, s2_in;
   logic [ptb_pkg::PIX_W-1:0]    xlat_q_ff;
   logic [ptb_pkg::TDATA_W-1:0]  fg_q_ff;
   logic [ptb_pkg::TDATA_W-1:0]  bg_q_ff;
   logic                         use_xlat;
   logic [ptb_pkg::PIX_W-1:0]    fg_addr;

   // Advance stage one
   always_comb begin
      s1_in = s1_ff;
      if (adv) begin
         s1_in = in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.vld <= 1'b0;
      end else begin
         s1_ff.vld <= s1_in.vld;
      end
      s1_ff.func  <= s1_in.func;
      s1_ff.src   <= s1_in.src;
      s1_ff.bg    <= s1_in.bg;
      s1_ff.tidx  <= s1_in.tidx;
      s1_ff.tdata <= s1_in.tdata;
   end

   // Translation table: write on load, read source index
   always_ff @(posedge clock) begin
      if (adv && in_item.vld && (in_item.func == ptb_pkg::FUNC_LOAD_XLAT)) begin
         xlat_mem[in_item.tidx[7:0]] <= in_item.tdata[7:0];
      end
      if (adv) begin
         xlat_q_ff <= xlat_mem[in_item.src];
      end
   end

   // Pick foreground index, translated or raw
   assign use_xlat = (style == ptb_pkg::STYLE_TRANSLATED) ||
                     (style == ptb_pkg::STYLE_XLAT_BLEND);
   assign fg_addr  = use_xlat ? xlat_q_ff : s1_ff.src;

   // Advance stage two
   always_comb begin
      s2_in = s2_ff;
      if (adv) begin
         s2_in     = s1_ff;
         s2_in.src = fg_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.vld <= 1'b0;
      end else begin
         s2_ff.vld <= s2_in.vld;
      end
      s2_ff.func  <= s2_in.func;
      s2_ff.src   <= s2_in.src;
      s2_ff.bg    <= s2_in.bg;
      s2_ff.tidx  <= s2_in.tidx;
      s2_ff.tdata <= s2_in.tdata;
   end

   // Weight tables: write on load, read foreground and background weights
   always_ff @(posedge clock) begin
      if (adv && s1_ff.vld && (s1_ff.func == ptb_pkg::FUNC_LOAD_FG)) begin
         fg_mem[s1_ff.tidx[7:0]] <= s1_ff.tdata;
      end
      if (adv) begin
         fg_q_ff <= fg_mem[fg_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s1_ff.vld && (s1_ff.func == ptb_pkg::FUNC_LOAD_BG)) begin
         bg_mem[s1_ff.tidx[7:0]] <= s1_ff.tdata;
      end
      if (adv) begin
         bg_q_ff <= bg_mem[s1_ff.bg];
      end
   end

   assign s2_item   = s2_ff;
   assign fg_weight = fg_q_ff;
   assign bg_weight = bg_q_ff;

endmodule

// ----- rtl/core/ptb_mix_lookup.sv -----
// ----------------------------------------------------------------------------
// ptb_mix_lookup
// Forms the blend index from the two weights and reads the mixing table.
// Mix loads write in the same stage that draws read it.
// ----------------------------------------------------------------------------
module ptb_mix_lookup #(
   parameter int unsigned MIX_ENTRIES = 8192
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             adv,
   input  ptb_pkg::item_type                s2_item,
   input  logic [ptb_pkg::TDATA_W-1:0]      fg_weight,
   input  logic [ptb_pkg::TDATA_W-1:0]      bg_weight,
   output ptb_pkg::item_type                s3_item,
   output logic [ptb_pkg::PIX_W-1:0]        mix_pixel
);

   localparam int unsigned MIX_AW = $clog2(MIX_ENTRIES);

   logic [ptb_pkg::PIX_W-1:0]    mix_mem [MIX_ENTRIES];

   ptb_pkg::item_type            s3_ff, s3_in;
   logic [ptb_pkg::PIX_W-1:0]    mix_q_ff;
   logic [ptb_pkg::TDATA_W-1:0]  weight_sum;
   logic [ptb_pkg::TDATA_W-1:0]  blend_word;
   logic [MIX_AW-1:0]            mix_addr;

   // Sum weights, force the guard bits, fold the two channel groups
   assign weight_sum = (fg_weight + bg_weight) | ptb_pkg::BLEND_OR_MASK;
   assign blend_word = (weight_sum >> ptb_pkg::BLEND_SHIFT_LO) &
                       (weight_sum >> ptb_pkg::BLEND_SHIFT_HI);
   assign mix_addr   = blend_word[MIX_AW-1:0];

   // Advance stage three
   always_comb begin
      s3_in = s3_ff;
      if (adv) begin
         s3_in = s2_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ff.vld <= 1'b0;
      end else begin
         s3_ff.vld <= s3_in.vld;
      end
      s3_ff.func  <= s3_in.func;
      s3_ff.src   <= s3_in.src;
      s3_ff.bg    <= s3_in.bg;
      s3_ff.tidx  <= s3_in.tidx;
      s3_ff.tdata <= s3_in.tdata;
   end

   // Mixing table: write on load, read blend index
   always_ff @(posedge clock) begin
      if (adv && s2_item.vld && (s2_item.func == ptb_pkg::FUNC_LOAD_MIX)) begin
         mix_mem[s2_item.tidx[MIX_AW-1:0]] <= s2_item.tdata[7:0];
      end
      if (adv) begin
         mix_q_ff <= mix_mem[mix_addr];
      end
   end

   assign s3_item   = s3_ff;
   assign mix_pixel = mix_q_ff;

endmodule

// ----- rtl/core/ptb_out_buf.sv -----
// ----------------------------------------------------------------------------
// ptb_out_buf
// Output register with one skid entry; decouples the pipeline from the
// receiver so the stall signal toward the pipeline is registered.
// ----------------------------------------------------------------------------
module ptb_out_buf (
   input  logic                             clock,
   input  logic                             reset,
   input  ptb_pkg::buf_push_type            push,
   output ptb_pkg::buf_status_type          status,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [ptb_pkg::PIX_W-1:0]        rsp_out_pixel
);

   logic                       out_vld_ff, out_vld_in;
   logic [ptb_pkg::PIX_W-1:0]  out_pix_ff, out_pix_in;
   logic                       skid_vld_ff, skid_vld_in;
   logic [ptb_pkg::PIX_W-1:0]  skid_pix_ff, skid_pix_in;

   // Move transactions between pipeline, skid entry and output register
   always_comb begin
      out_vld_in  = out_vld_ff;
      out_pix_in  = out_pix_ff;
      skid_vld_in = skid_vld_ff;
      skid_pix_in = skid_pix_ff;
      if (out_vld_ff && rsp_ready) begin
         if (skid_vld_ff) begin
            out_pix_in  = skid_pix_ff;
            skid_vld_in = 1'b0;
         end else if (push.push) begin
            out_pix_in = push.pix;
         end else begin
            out_vld_in = 1'b0;
         end
      end else if (!out_vld_ff) begin
         if (push.push) begin
            out_vld_in = 1'b1;
            out_pix_in = push.pix;
         end
      end else if (push.push) begin
         skid_vld_in = 1'b1;
         skid_pix_in = push.pix;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
      out_pix_ff  <= out_pix_in;
      skid_pix_ff <= skid_pix_in;
   end

   assign status.full   = skid_vld_ff;
   assign status.busy   = out_vld_ff;
   assign rsp_valid     = out_vld_ff;
   assign rsp_out_pixel = out_pix_ff;

   // The skid entry only fills behind a waiting output
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid entry holds data while output register is empty");

   // The pipeline never pushes into a full buffer
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push.push |-> !skid_vld_ff)
      else $error("push into full output buffer");

   // A stalled buffer with a spare entry catches the pushed transaction
   a_push_caught: assert property (@(posedge clock) disable iff (reset)
      (push.push && out_vld_ff && !rsp_ready) |=> skid_vld_ff)
      else $error("pushed transaction lost while output stalled");

endmodule

// ----- rtl/core/palette_translucency_blend.sv -----
// ----------------------------------------------------------------------------
// palette_translucency_blend
// Per-pixel palette compositor: plain, translated, translucent and
// translated-then-translucent styles over four loadable lookup tables.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one transaction per valid/ready handshake: a draw (func 0)
//   or a table load (func 1..4). Codes 5..7 are dropped. Each draw yields one
//   transaction on rsp_*; loads yield none.
//   csr_* is a register port; draw_style lies at byte address 0. Write it
//   only while no draw is in flight.
//   Throughput: one transaction per clock while req_ready is high. Each
//   pixel is a chain of three table reads (translation, weights, mix), one
//   memory stage per read, and loads write their table in the stage where
//   draws read it, so load and draw order is kept without forwarding.
//   A draw is registered after the translation read, the weight reads, the
//   mix read and then the output register before it shows on rsp_valid.
//   Reset clears the style register and all valid bits; table contents are
//   not cleared and must be loaded before they are read.
//   When the receiver stalls, the output register and one skid entry absorb
//   results; req_ready drops once the skid entry is full and the whole
//   pipeline holds until the receiver takes a transaction.
// ----------------------------------------------------------------------------
module palette_translucency_blend #(
   parameter int unsigned MIX_ENTRIES = 8192
) (
   input  logic                              clock,
   input  logic                              reset,
   // input channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ptb_pkg::FUNC_W-1:0]        req_func,
   input  logic [ptb_pkg::PIX_W-1:0]         req_src_pixel,
   input  logic [ptb_pkg::PIX_W-1:0]         req_bg_pixel,
   input  logic [ptb_pkg::TIDX_W-1:0]        req_table_index,
   input  logic [ptb_pkg::TDATA_W-1:0]       req_table_data,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ptb_pkg::PIX_W-1:0]         rsp_out_pixel,
   // register port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ptb_pkg::CSR_AW-1:0]        csr_paddr,
   input  logic [ptb_pkg::CSR_DW-1:0]        csr_pwdata,
   output logic [ptb_pkg::CSR_DW-1:0]        csr_prdata,
   output logic                              csr_pready
);

   logic [ptb_pkg::STYLE_W-1:0]  style_ff, style_in;
   logic                         style_sel;
   logic                         adv;
   logic                         accept;
   logic                         use_blend;
   ptb_pkg::item_type            in_item;
   ptb_pkg::item_type            s2_item;
   ptb_pkg::item_type            s3_item;
   logic [ptb_pkg::TDATA_W-1:0]  fg_weight;
   logic [ptb_pkg::TDATA_W-1:0]  bg_weight;
   logic [ptb_pkg::PIX_W-1:0]    mix_pixel;
   ptb_pkg::buf_push_type        buf_push;
   ptb_pkg::buf_status_type      buf_status;

   // Register port: draw_style at word 0
   assign csr_pready = 1'b1;
   assign style_sel  = (csr_paddr[2] == ptb_pkg::CSR_REG_DRAW_STYLE);

   always_comb begin
      style_in = style_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && style_sel) begin
         style_in = csr_pwdata[ptb_pkg::STYLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         style_ff <= ptb_pkg::STYLE_PLAIN;
      end else begin
         style_ff <= style_in;
      end
   end

   assign csr_prdata = style_sel ?
                       {{(ptb_pkg::CSR_DW-ptb_pkg::STYLE_W){1'b0}}, style_ff} :
                       '0;

   // Whole pipeline moves while the output buffer has room
   assign adv       = !buf_status.full;
   assign req_ready = adv;
   assign accept    = req_valid && req_ready;

   // Drop unused function codes at the door
   always_comb begin
      in_item.vld   = accept && (req_func <= ptb_pkg::FUNC_LOAD_MIX);
      in_item.func  = req_func;
      in_item.src   = req_src_pixel;
      in_item.bg    = req_bg_pixel;
      in_item.tidx  = req_table_index;
      in_item.tdata = req_table_data;
   end

   ptb_weight_lookup u_weight (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .style     (style_ff),
      .in_item   (in_item),
      .s2_item   (s2_item),
      .fg_weight (fg_weight),
      .bg_weight (bg_weight)
   );

   ptb_mix_lookup #(
      .MIX_ENTRIES (MIX_ENTRIES)
   ) u_mix (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .s2_item   (s2_item),
      .fg_weight (fg_weight),
      .bg_weight (bg_weight),
      .s3_item   (s3_item),
      .mix_pixel (mix_pixel)
   );

   // Select final pixel for draws
   assign use_blend = (style_ff == ptb_pkg::STYLE_TRANSLUCENT) ||
                      (style_ff == ptb_pkg::STYLE_XLAT_BLEND);

   assign buf_push.push = adv && s3_item.vld && (s3_item.func == ptb_pkg::FUNC_DRAW);
   assign buf_push.pix  = use_blend ? mix_pixel : s3_item.src;

   ptb_out_buf u_out (
      .clock         (clock),
      .reset         (reset),
      .push          (buf_push),
      .status        (buf_status),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_pixel (rsp_out_pixel)
   );

   // Held pipeline keeps the last stage and the mix read intact
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (!adv && !$past(reset)) |=> ($stable(s3_item) && $stable(mix_pixel)))
      else $error("pipeline stage changed during stall");

   // A full buffer blocks new input
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      buf_status.full |-> (!req_ready && buf_status.busy))
      else $error("input accepted while output buffer full");

   // Undefined function codes never reach the pipeline
   a_bad_func_dropped: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_func > ptb_pkg::FUNC_LOAD_MIX)) |=> !$past(in_item.vld))
      else $error("unused function code entered the pipeline");

endmodule

// ----- test/tb_palette_translucency_blend.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_palette_translucency_blend
// Self-checking bench for the palette compositor. Loads the lookup tables,
// runs draws in all four styles, and checks every pixel against an in-bench
// model of the tables and the blend index, under random and long stalls.
// ----------------------------------------------------------------------------
module tb_palette_translucency_blend;

   localparam int CLK_HALF      = 4;
   localparam int RESET_CYCLES  = 8;
   localparam int LIMIT_CYCLES  = 400000;
   localparam int DRAIN_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_CYCLES   = 400;
   localparam int PHASE_ITEMS   = 230;
   localparam int NUM_PHASES    = 6;
   localparam int MAX_PRINTS    = 40;

   localparam logic [ptb_pkg::CSR_AW-1:0] STYLE_ADDR  = {ptb_pkg::CSR_REG_DRAW_STYLE, 2'b00};
   localparam logic [ptb_pkg::CSR_AW-1:0] UNUSED_ADDR = 3'd4;
   localparam logic [ptb_pkg::FUNC_W-1:0] FUNC_FIRST_UNUSED = ptb_pkg::FUNC_LOAD_MIX + 3'd1;
   localparam logic [ptb_pkg::FUNC_W-1:0] FUNC_LAST_CODE    = 3'd7;

   typedef struct {
      logic [ptb_pkg::FUNC_W-1:0]  func;
      logic [ptb_pkg::PIX_W-1:0]   src;
      logic [ptb_pkg::PIX_W-1:0]   bg;
      logic [ptb_pkg::TIDX_W-1:0]  tidx;
      logic [ptb_pkg::TDATA_W-1:0] tdata;
   } pixel_op_type;

   // Clock, reset and block ports
   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [ptb_pkg::FUNC_W-1:0]    req_func = '0;
   logic [ptb_pkg::PIX_W-1:0]     req_src_pixel = '0;
   logic [ptb_pkg::PIX_W-1:0]     req_bg_pixel = '0;
   logic [ptb_pkg::TIDX_W-1:0]    req_table_index = '0;
   logic [ptb_pkg::TDATA_W-1:0]   req_table_data = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [ptb_pkg::PIX_W-1:0]     rsp_out_pixel;
   logic                          csr_psel = 1'b0;
   logic                          csr_penable = 1'b0;
   logic                          csr_pwrite = 1'b0;
   logic [ptb_pkg::CSR_AW-1:0]    csr_paddr = '0;
   logic [ptb_pkg::CSR_DW-1:0]    csr_pwdata = '0;
   logic [ptb_pkg::CSR_DW-1:0]    csr_prdata;
   logic                          csr_pready;

   // Stimulus queue and the transaction now on the input channel
   pixel_op_type                  pending_ops[$];
   pixel_op_type                  on_wire;
   logic [ptb_pkg::PIX_W-1:0]     pixel_expect[$];
   logic [ptb_pkg::PIX_W-1:0]     want_pix;

   // Table contents as planned by the stimulus, with written flags
   logic [ptb_pkg::PIX_W-1:0]     plan_xlat [256];
   logic [ptb_pkg::TDATA_W-1:0]   plan_fg [256];
   logic [ptb_pkg::TDATA_W-1:0]   plan_bg [256];
   bit                            xlat_set [256];
   bit                            fg_set [256];
   bit                            bg_set [256];
   bit                            mix_set [8192];

   // Predicted block state, updated as transactions are accepted
   logic [ptb_pkg::STYLE_W-1:0]   style_reg = ptb_pkg::STYLE_PLAIN;
   logic [ptb_pkg::PIX_W-1:0]     xlat_mem [256];
   logic [ptb_pkg::TDATA_W-1:0]   fg_mem [256];
   logic [ptb_pkg::TDATA_W-1:0]   bg_mem [256];
   logic [ptb_pkg::PIX_W-1:0]     mix_mem [8192];

   int                            send_idle_pct = 21;
   int                            recv_idle_pct = 79;
   bit                            hold_req = 1'b0;
   bit                            hold_seen = 1'b0;
   int                            hold_left = 0;
   int                            err_count = 0;
   int                            cycle_count = 0;
   int                            queued_total = 0;

   palette_translucency_blend i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_src_pixel   (req_src_pixel),
      .req_bg_pixel    (req_bg_pixel),
      .req_table_index (req_table_index),
      .req_table_data  (req_table_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_pixel   (rsp_out_pixel),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always #(CLK_HALF) clock = ~clock;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (err_count < MAX_PRINTS) begin
         $display("MISMATCH %s: got %0h, expected %0h (cycle %0d)",
                  what, got, want, cycle_count);
      end
      err_count++;
   endtask

   // Mixing-table slot for a pair of weight words; the sum wraps at 32 bits
   function automatic logic [ptb_pkg::TIDX_W-1:0] mix_slot(
      input logic [ptb_pkg::TDATA_W-1:0] fg_w,
      input logic [ptb_pkg::TDATA_W-1:0] bg_w);
      logic [ptb_pkg::TDATA_W-1:0] sum;
      logic [ptb_pkg::TDATA_W-1:0] slot;
      sum  = (fg_w + bg_w) | ptb_pkg::BLEND_OR_MASK;
      slot = (sum >> ptb_pkg::BLEND_SHIFT_LO) & (sum >> ptb_pkg::BLEND_SHIFT_HI);
      return slot[ptb_pkg::TIDX_W-1:0];
   endfunction

   // Queue one transaction and track what the tables will hold after it
   function automatic void queue_op(input logic [ptb_pkg::FUNC_W-1:0] func,
                                    input logic [ptb_pkg::TIDX_W-1:0] tidx,
                                    input logic [ptb_pkg::TDATA_W-1:0] tdata,
                                    input logic [ptb_pkg::PIX_W-1:0] src,
                                    input logic [ptb_pkg::PIX_W-1:0] bg);
      pixel_op_type op;
      op.func  = func;
      op.src   = src;
      op.bg    = bg;
      op.tidx  = tidx;
      op.tdata = tdata;
      pending_ops.push_back(op);
      queued_total++;
      case (func)
         ptb_pkg::FUNC_LOAD_XLAT: begin
            plan_xlat[tidx[ptb_pkg::PIX_W-1:0]] = tdata[ptb_pkg::PIX_W-1:0];
            xlat_set[tidx[ptb_pkg::PIX_W-1:0]]  = 1'b1;
         end
         ptb_pkg::FUNC_LOAD_FG: begin
            plan_fg[tidx[ptb_pkg::PIX_W-1:0]] = tdata;
            fg_set[tidx[ptb_pkg::PIX_W-1:0]]  = 1'b1;
         end
         ptb_pkg::FUNC_LOAD_BG: begin
            plan_bg[tidx[ptb_pkg::PIX_W-1:0]] = tdata;
            bg_set[tidx[ptb_pkg::PIX_W-1:0]]  = 1'b1;
         end
         ptb_pkg::FUNC_LOAD_MIX: mix_set[tidx] = 1'b1;
         default: ;
      endcase
   endfunction

   function automatic void queue_load(input logic [ptb_pkg::FUNC_W-1:0] func,
                                      input logic [ptb_pkg::TIDX_W-1:0] tidx);
      queue_op(func, tidx, $urandom, 8'($urandom), 8'($urandom));
   endfunction

   // Queue a draw, preceded by loads of any table entry it would read unwritten
   function automatic void queue_draw(input logic [ptb_pkg::PIX_W-1:0] src,
                                      input logic [ptb_pkg::PIX_W-1:0] bg);
      logic [ptb_pkg::PIX_W-1:0]  fg_sel;
      logic [ptb_pkg::TIDX_W-1:0] slot;
      fg_sel = src;
      if (style_reg == ptb_pkg::STYLE_TRANSLATED ||
          style_reg == ptb_pkg::STYLE_XLAT_BLEND) begin
         if (!xlat_set[src]) queue_load(ptb_pkg::FUNC_LOAD_XLAT, {5'($urandom), src});
         fg_sel = plan_xlat[src];
      end
      if (style_reg == ptb_pkg::STYLE_TRANSLUCENT ||
          style_reg == ptb_pkg::STYLE_XLAT_BLEND) begin
         if (!fg_set[fg_sel]) queue_load(ptb_pkg::FUNC_LOAD_FG, {5'($urandom), fg_sel});
         if (!bg_set[bg]) queue_load(ptb_pkg::FUNC_LOAD_BG, {5'($urandom), bg});
         slot = mix_slot(plan_fg[fg_sel], plan_bg[bg]);
         if (!mix_set[slot]) queue_load(ptb_pkg::FUNC_LOAD_MIX, slot);
      end
      queue_op(ptb_pkg::FUNC_DRAW, 13'($urandom), $urandom, src, bg);
   endfunction

   // Apply one accepted transaction to the predicted state
   task automatic predict_item(input pixel_op_type op);
      logic [ptb_pkg::PIX_W-1:0] fg_sel;
      logic [ptb_pkg::PIX_W-1:0] pix;
      case (op.func)
         ptb_pkg::FUNC_DRAW: begin
            fg_sel = (style_reg == ptb_pkg::STYLE_XLAT_BLEND) ? xlat_mem[op.src] : op.src;
            case (style_reg)
               ptb_pkg::STYLE_PLAIN:      pix = op.src;
               ptb_pkg::STYLE_TRANSLATED: pix = xlat_mem[op.src];
               default: pix = mix_mem[mix_slot(fg_mem[fg_sel], bg_mem[op.bg])];
            endcase
            pixel_expect.push_back(pix);
         end
         ptb_pkg::FUNC_LOAD_XLAT:
            xlat_mem[op.tidx[ptb_pkg::PIX_W-1:0]] = op.tdata[ptb_pkg::PIX_W-1:0];
         ptb_pkg::FUNC_LOAD_FG:   fg_mem[op.tidx[ptb_pkg::PIX_W-1:0]] = op.tdata;
         ptb_pkg::FUNC_LOAD_BG:   bg_mem[op.tidx[ptb_pkg::PIX_W-1:0]] = op.tdata;
         ptb_pkg::FUNC_LOAD_MIX:  mix_mem[op.tidx] = op.tdata[ptb_pkg::PIX_W-1:0];
         default: ;
      endcase
   endtask

   // Input driver: predict on acceptance, then offer the next transaction
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) predict_item(on_wire);
         if (!req_valid || req_ready) begin
            if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               on_wire = pending_ops.pop_front();
               req_valid       <= 1'b1;
               req_func        <= on_wire.func;
               req_src_pixel   <= on_wire.src;
               req_bg_pixel    <= on_wire.bg;
               req_table_index <= on_wire.tidx;
               req_table_data  <= on_wire.tdata;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor and receiver stalls, with the long hold-off on request
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pixel_expect.size() == 0) begin
            report_mismatch("unexpected out_pixel", 32'(rsp_out_pixel), 0);
         end else begin
            want_pix = pixel_expect.pop_front();
            if (rsp_out_pixel !== want_pix) begin
               report_mismatch("out_pixel", 32'(rsp_out_pixel), 32'(want_pix));
            end
         end
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (hold_req != hold_seen) begin
         hold_seen = hold_req;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // One register access: setup phase, then access phase until pready
   task automatic csr_access(input logic wr, input logic [ptb_pkg::CSR_AW-1:0] addr,
                             input logic [ptb_pkg::CSR_DW-1:0] wdata,
                             output logic [ptb_pkg::CSR_DW-1:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Write a register, then read draw_style back; unused addresses are ignored
   task automatic write_csr(input logic [ptb_pkg::CSR_AW-1:0] addr,
                            input logic [ptb_pkg::STYLE_W-1:0] value);
      logic [ptb_pkg::CSR_DW-1:0] wdata;
      logic [ptb_pkg::CSR_DW-1:0] rdata;
      wdata = $urandom;
      wdata[ptb_pkg::STYLE_W-1:0] = value;
      csr_access(1'b1, addr, wdata, rdata);
      if (addr == STYLE_ADDR) style_reg = value;
      csr_access(1'b0, STYLE_ADDR, '0, rdata);
      if (rdata !== ptb_pkg::CSR_DW'(style_reg)) begin
         report_mismatch("draw_style readback", rdata, 32'(style_reg));
      end
   endtask

   // Let the queue empty and all results arrive, then let loads retire
   task automatic finish_phase();
      int waited;
      waited = 0;
      while (pending_ops.size() != 0 || req_valid) @(posedge clock);
      while (pixel_expect.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pixel_expect.size() != 0) begin
         report_mismatch("results never delivered", pixel_expect.size(), 0);
         pixel_expect.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [ptb_pkg::STYLE_W-1:0] phase_style [NUM_PHASES];
      int                          phase_start;
      int                          pick;
      phase_style[0] = ptb_pkg::STYLE_XLAT_BLEND;
      phase_style[1] = ptb_pkg::STYLE_TRANSLUCENT;
      phase_style[2] = ptb_pkg::STYLE_TRANSLATED;
      phase_style[3] = ptb_pkg::STYLE_PLAIN;
      phase_style[4] = ptb_pkg::STYLE_XLAT_BLEND;
      phase_style[5] = ptb_pkg::STYLE_TRANSLUCENT;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Plain style from reset: extremes, unused codes, table loads, then a draw
      queue_draw(8'h00, 8'h00);
      queue_draw(8'hff, 8'hff);
      queue_op(FUNC_FIRST_UNUSED, 13'($urandom), $urandom, 8'($urandom), 8'($urandom));
      queue_op(FUNC_FIRST_UNUSED + 3'd1, 13'($urandom), $urandom,
               8'($urandom), 8'($urandom));
      queue_op(FUNC_LAST_CODE, 13'($urandom), $urandom, 8'($urandom), 8'($urandom));
      queue_op(ptb_pkg::FUNC_LOAD_XLAT, 13'h1f00, 32'hffffffff, 8'($urandom), 8'($urandom));
      queue_op(ptb_pkg::FUNC_LOAD_XLAT, 13'h00ff, 32'h00000000, 8'($urandom), 8'($urandom));
      queue_op(ptb_pkg::FUNC_LOAD_FG,   13'h0000, 32'hffffffff, 8'($urandom), 8'($urandom));
      queue_op(ptb_pkg::FUNC_LOAD_FG,   13'h1eff, 32'h00000001, 8'($urandom), 8'($urandom));
      queue_op(ptb_pkg::FUNC_LOAD_BG,   13'h0000, 32'hffffffff, 8'($urandom), 8'($urandom));
      queue_op(ptb_pkg::FUNC_LOAD_BG,   13'h00ff, 32'h00000000, 8'($urandom), 8'($urandom));
      queue_op(ptb_pkg::FUNC_LOAD_MIX,  13'h1fff, 32'h000000ff, 8'($urandom), 8'($urandom));
      queue_op(ptb_pkg::FUNC_LOAD_MIX,  13'h0000, 32'hffffff00, 8'($urandom), 8'($urandom));
      queue_draw(8'h00, 8'hff);
      finish_phase();

      write_csr(STYLE_ADDR, ptb_pkg::STYLE_TRANSLATED);
      queue_draw(8'h00, 8'h00);
      queue_draw(8'hff, 8'hff);
      finish_phase();

      // Weight sums at both ends of the mixing table, two of them wrapping
      write_csr(STYLE_ADDR, ptb_pkg::STYLE_TRANSLUCENT);
      queue_draw(8'h00, 8'h00);
      queue_draw(8'hff, 8'hff);
      queue_draw(8'h00, 8'hff);
      queue_draw(8'hff, 8'h00);
      finish_phase();

      write_csr(STYLE_ADDR, ptb_pkg::STYLE_XLAT_BLEND);
      queue_draw(8'h00, 8'h00);
      queue_draw(8'hff, 8'hff);
      finish_phase();

      // A write beyond the style register leaves the style alone
      write_csr(UNUSED_ADDR, ptb_pkg::STYLE_PLAIN);
      queue_draw(8'h00, 8'hff);
      finish_phase();

      // Random phases: two per idle pattern; only phase 0 gets a long hold
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase / 2)
            0: begin
               send_idle_pct = 21;
               recv_idle_pct = 79;
            end
            1: begin
               send_idle_pct = 79;
               recv_idle_pct = 21;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         write_csr(STYLE_ADDR, phase_style[phase]);
         phase_start = queued_total;
         while (queued_total - phase_start < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
               queue_draw(8'($urandom), 8'($urandom));
            end else if (pick < 70) begin
               queue_load(ptb_pkg::FUNC_LOAD_XLAT, 13'($urandom));
            end else if (pick < 78) begin
               queue_load(ptb_pkg::FUNC_LOAD_FG, 13'($urandom));
            end else if (pick < 86) begin
               queue_load(ptb_pkg::FUNC_LOAD_BG, 13'($urandom));
            end else if (pick < 95) begin
               queue_load(ptb_pkg::FUNC_LOAD_MIX, 13'($urandom));
            end else begin
               queue_op(3'($urandom_range(FUNC_FIRST_UNUSED, FUNC_LAST_CODE)),
                        13'($urandom), $urandom, 8'($urandom), 8'($urandom));
            end
         end
         if (phase == 0) hold_req = ~hold_req;
         finish_phase();
      end

      if (err_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
